[sv/lss_pkg.sv]
// Shared types and codes for the LIFO stack with search.
`timescale 1ns / 1ps

package lss_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] operand;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] top_value;
    logic [POS_W-1:0]         found_position;
  } out_t;

endpackage

[sv/lss_mem.sv]
// Stack storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lss_mem #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic signed [lss_pkg::DATA_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic signed [lss_pkg::DATA_W-1:0] rd_data
);

  logic signed [lss_pkg::DATA_W-1:0] store_r [DEPTH];
  logic signed [lss_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/lss_ctrl.sv]
// Request sequencer: occupancy, top-down search walk and result register.
`timescale 1ns / 1ps

module lss_ctrl #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lss_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lss_pkg::out_t                     out_data,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic signed [lss_pkg::DATA_W-1:0] wr_data,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic signed [lss_pkg::DATA_W-1:0] rd_data,
  output logic [CW-1:0]                     occ,
  output logic                              busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     occ_r, occ_nxt;
  logic                              out_valid_r, out_valid_nxt;
  lss_pkg::out_t                     out_data_r, out_data_nxt;
  logic [AW-1:0]                     ptr_r, ptr_nxt;
  logic [CW-1:0]                     pos_r, pos_nxt;
  logic                              is_peek_r, is_peek_nxt;
  logic signed [lss_pkg::DATA_W-1:0] operand_r, operand_nxt;
  logic                              in_accept;
  logic                              out_free;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    is_peek_nxt   = is_peek_r;
    operand_nxt   = operand_r;
    wr_en         = 1'b0;
    wr_addr       = AW'(occ_r);
    wr_data       = in_data.operand;
    rd_en         = 1'b0;
    rd_addr       = ptr_r - 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = lss_pkg::ST_OK;
          out_data_nxt.top_value      = '0;
          out_data_nxt.found_position = '0;
          if (in_data.action == lss_pkg::ACT_PUSH) begin
            if (occ_r == CW'(DEPTH)) begin
              out_data_nxt.status = lss_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              occ_nxt = occ_r + 1'b1;
            end
          end else if (occ_r == '0) begin
            out_data_nxt.status = lss_pkg::ST_EMPTY;
          end else if (in_data.action == lss_pkg::ACT_POP) begin
            occ_nxt = occ_r - 1'b1;
          end else begin
            // peek or search: fetch the top entry, finish once it is back
            out_valid_nxt = 1'b0;
            rd_en         = 1'b1;
            rd_addr       = AW'(occ_r - 1'b1);
            ptr_nxt       = AW'(occ_r - 1'b1);
            pos_nxt       = CW'(1);
            is_peek_nxt   = (in_data.action == lss_pkg::ACT_PEEK);
            operand_nxt   = in_data.operand;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at ptr_r, position pos_r from the top
        if (out_free) begin
          out_data_nxt.status         = lss_pkg::ST_OK;
          out_data_nxt.top_value      = '0;
          out_data_nxt.found_position = '0;
          if (is_peek_r) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.top_value = rd_data;
            state_nxt              = S_IDLE;
          end else if (rd_data == operand_r) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.found_position = lss_pkg::POS_W'(pos_r);
            state_nxt                   = S_IDLE;
          end else if (ptr_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = lss_pkg::ST_MISS;
            state_nxt           = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            ptr_nxt = ptr_r - 1'b1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ptr_r      <= ptr_nxt;
    pos_r      <= pos_nxt;
    is_peek_r  <= is_peek_nxt;
    operand_r  <= operand_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign occ       = occ_r;
  assign busy      = (state_r != S_IDLE);

endmodule

[sv/lifo_stack_with_search.sv]
// Bounded LIFO stack of signed 32-bit values with push, pop, peek and top-down search.
`timescale 1ns / 1ps

// Holds up to DEPTH entries in a single-port-read synchronous memory. Push and pop
// complete in the cycle they are taken, so one may follow every cycle while the output
// is not stalled. Peek first reads the top entry out of the memory, then returns it.
// Search reads one entry per cycle from the top down while the output is free, until
// it finds a match or has read every entry; the memory read port sets this pace.
// Results pass through an output register; the input is stalled while a result waits
// under out_stall and while a peek or search is in progress. Positions wider than five
// bits are truncated.

module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lss_pkg::out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [lss_pkg::DATA_W-1:0] wr_data;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic signed [lss_pkg::DATA_W-1:0] rd_data;
  logic [CW-1:0]                     occ;
  logic                              busy;

  lss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .occ       (occ),
    .busy      (busy)
  );

  lss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input taken during a search walk");

  a_occ_held: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall) |=> $stable(occ))
    else $error("occupancy changed without an input beat");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en)
    else $error("memory write during a search walk");
`endif

endmodule

[dv/lifo_stack_with_search_test.sv]
// Self-checking testbench for the LIFO stack with search: directed and random requests.
`timescale 1ns / 1ps

module lifo_stack_with_search_test;
  import lss_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1900;

  // Shadow copy of the stack; works out the reply owed for each accepted request.
  class stack_checker;
    logic signed [DATA_W-1:0] shadow[STACK_DEPTH];
    int unsigned level;
    out_t awaited_replies[$];
    int unsigned errors;

    function new();
      level = 0;
      errors = 0;
    endfunction

    function void note_request(in_t req);
      out_t reply;
      bit hit;
      reply = '0;
      reply.status = ST_OK;
      hit = 1'b0;
      if (req.action == ACT_PUSH) begin
        if (level >= STACK_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          shadow[level] = req.operand;
          level++;
        end
      end else if (level == 0) begin
        reply.status = ST_EMPTY;
      end else if (req.action == ACT_POP) begin
        level--;
      end else if (req.action == ACT_PEEK) begin
        reply.top_value = shadow[level-1];
      end else begin
        // first match counting down from the top wins
        for (int k = 0; k < level; k++) begin
          if (!hit && shadow[level-1-k] == req.operand) begin
            hit = 1'b1;
            reply.found_position = POS_W'(k + 1);
          end
        end
        if (!hit) reply.status = ST_MISS;
      end
      awaited_replies.push_back(reply);
    endfunction

    function logic signed [DATA_W-1:0] entry_from_top(int unsigned k);
      return shadow[level-1-k];
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result beat status %0d top_value %0d found_position %0d",
                 $time, got.status, got.top_value, got.found_position);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.top_value !== want.top_value) begin
        $display("%0t: top_value expected %0d actual %0d",
                 $time, want.top_value, got.top_value);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $display("%0t: found_position expected %0d actual %0d",
                 $time, want.found_position, got.found_position);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  stack_checker checker_h = new();
  bit idle_on = 1'b1;
  int unsigned cycles = 0;

  lifo_stack_with_search #(.DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) checker_h.check_result(out_data);
  end

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= idle_on && ($urandom_range(0, 99) < 7);
    end
  end

  // Called at a falling edge; returns at a falling edge after the beat is taken and any idle gap.
  task automatic send_beat(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
    in_t req;
    req.action = act;
    req.operand = val;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    checker_h.note_request(req);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 7)) - 4;  // narrow pool breeds duplicates
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beat(input int unsigned push_w, input int unsigned pop_w);
    int unsigned r;
    logic signed [DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    val = pick_value();
    if (r < push_w) begin
      send_beat(ACT_PUSH, val);
    end else if (r < push_w + pop_w) begin
      send_beat(ACT_POP, val);
    end else if (r < push_w + pop_w + 15) begin
      send_beat(ACT_PEEK, val);
    end else begin
      if (checker_h.level > 0 && $urandom_range(0, 9) < 6)
        val = checker_h.entry_from_top($urandom_range(0, checker_h.level - 1));
      send_beat(ACT_SEARCH, val);
    end
  endtask

  initial begin
    int unsigned push_w;
    int unsigned pop_w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner cases: requests on an empty stack, extreme values, duplicates, a search miss, draining
    send_beat(ACT_POP, 32'sd5);
    send_beat(ACT_PEEK, 32'sd0);
    send_beat(ACT_SEARCH, 32'sd0);
    send_beat(ACT_PUSH, 32'h7fff_ffff);
    send_beat(ACT_PUSH, 32'h8000_0000);
    send_beat(ACT_PUSH, 32'sd0);
    send_beat(ACT_PUSH, -32'sd1);
    send_beat(ACT_PUSH, 32'sd0);
    send_beat(ACT_PEEK, 32'sd9);
    send_beat(ACT_SEARCH, 32'sd0);
    send_beat(ACT_SEARCH, 32'h7fff_ffff);
    send_beat(ACT_SEARCH, 32'h8000_0000);
    send_beat(ACT_SEARCH, 32'h7fff_fffe);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_PEEK, 32'sd0);
    repeat (4) send_beat(ACT_POP, -32'sd1);
    send_beat(ACT_PEEK, 32'sd0);

    // phases lean towards filling, draining or mixing so full and empty both occur
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_w = 60; pop_w = 10; end
          1: begin push_w = 10; pop_w = 50; end
          default: begin push_w = 30; pop_w = 25; end
        endcase
      end
      idle_on = !(n >= 800 && n < 1200);
      random_beat(push_w, pop_w);
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    while (checker_h.awaited_replies.size() != 0) @(posedge clk);
    repeat (3 * STACK_DEPTH) @(posedge clk);
    if (checker_h.errors == 0 && checker_h.awaited_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
